@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL that checks itself.
// Each macro names the assertion, samples on the rising clock edge and
// is disabled while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ftx_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftx_pkg
// Types and constants of the IPv4 five-tuple extractor.
// ----------------------------------------------------------------------------
package ftx_pkg;

    localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
    localparam logic [15:0] IPV4_MIN_END  = 16'd34;
    localparam logic [15:0] TCP_MIN_LEN   = 16'd20;
    localparam logic [15:0] UDP_MIN_LEN   = 16'd8;
    localparam logic [15:0] TYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [2:0]  IPV4_VER      = 3'd4;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Fixed byte positions in an untagged Ethernet frame.
    localparam logic [15:0] POS_TYPE_HI   = 16'd12;
    localparam logic [15:0] POS_TYPE_LO   = 16'd13;
    localparam logic [15:0] POS_VER_IHL   = 16'd14;
    localparam logic [15:0] POS_TLEN_HI   = 16'd16;
    localparam logic [15:0] POS_TLEN_LO   = 16'd17;
    localparam logic [15:0] POS_PROTO     = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;

    typedef enum logic [1:0] {
        STATUS_NOT_IPV4 = 2'd0,
        STATUS_VALID    = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] eth_type;
        logic [2:0]  ip_ver;
        logic [7:0]  protocol;
        logic [15:0] ip_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
    } result_word_t;

    // Everything captured from one frame, handed from the parser to the
    // classifier when the last byte is taken.
    typedef struct packed {
        logic [15:0] frame_len;
        logic [15:0] eth_type;
        logic [3:0]  ihl;
        logic [7:0]  protocol;
        logic [15:0] ip_len;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_l4_port;
        logic [15:0] dst_l4_port;
    } frame_sum_t;

endpackage

@@ rtl/core/ftx_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftx_front
// Byte-wise header capture; emits a frame summary on the last byte.
// ----------------------------------------------------------------------------
module ftx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  ftx_pkg::in_word_t item,
    output logic              sum_valid,
    output ftx_pkg::frame_sum_t sum
);
    import ftx_pkg::*;

    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] type_reg;
    logic [15:0] type_next;
    logic [3:0]  ihl_reg;
    logic [3:0]  ihl_next;
    logic [7:0]  proto_reg;
    logic [7:0]  proto_next;
    logic [15:0] tlen_reg;
    logic [15:0] tlen_next;
    logic [31:0] src_reg;
    logic [31:0] src_next;
    logic [31:0] dst_reg;
    logic [31:0] dst_next;
    logic [15:0] sport_reg;
    logic [15:0] sport_next;
    logic [15:0] dport_reg;
    logic [15:0] dport_next;

    logic [7:0]  b;
    logic [15:0] pos;
    logic [15:0] port_off;

    assign b   = item.data_byte;
    assign pos = count_reg;

    // The IHL nibble arriving on this very byte already moves the port offset.
    assign port_off = ETH_HDR_LEN + {10'd0, ihl_next, 2'b00};

    always_comb
    begin
        type_next  = type_reg;
        ihl_next   = ihl_reg;
        tlen_next  = tlen_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;

        if (pos == POS_TYPE_HI)
        begin
            type_next[15:8] = b;
        end
        if (pos == POS_TYPE_LO)
        begin
            type_next[7:0] = b;
        end
        if (pos == POS_VER_IHL)
        begin
            ihl_next = b[3:0];
        end
        if (pos == POS_TLEN_HI)
        begin
            tlen_next[15:8] = b;
        end
        if (pos == POS_TLEN_LO)
        begin
            tlen_next[7:0] = b;
        end
        if (pos == POS_PROTO)
        begin
            proto_next = b;
        end
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
        begin
            src_next = {src_reg[23:0], b};
        end
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
        begin
            dst_next = {dst_reg[23:0], b};
        end

        if (pos == port_off)
        begin
            sport_next[15:8] = b;
        end
        else if (pos == port_off + 16'd1)
        begin
            sport_next[7:0] = b;
        end
        else if (pos == port_off + 16'd2)
        begin
            dport_next[15:8] = b;
        end
        else if (pos == port_off + 16'd3)
        begin
            dport_next[7:0] = b;
        end

        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
    end

    assign sum_valid = accept && item.last_byte;

    always_comb
    begin
        sum.frame_len   = count_next;
        sum.eth_type    = type_next;
        sum.ihl         = ihl_next;
        sum.protocol    = proto_next;
        sum.ip_len      = tlen_next;
        sum.src_addr    = src_next;
        sum.dst_addr    = dst_next;
        sum.src_l4_port = sport_next;
        sum.dst_l4_port = dport_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            type_reg  <= '0;
            ihl_reg   <= '0;
            proto_reg <= '0;
            tlen_reg  <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
        end
        else if (accept)
        begin
            if (item.last_byte)
            begin
                count_reg <= '0;
                type_reg  <= '0;
                ihl_reg   <= '0;
                proto_reg <= '0;
                tlen_reg  <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
                type_reg  <= type_next;
                ihl_reg   <= ihl_next;
                proto_reg <= proto_next;
                tlen_reg  <= tlen_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
            end
        end
    end

endmodule

@@ rtl/core/ftx_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftx_queue
// Small first-in first-out buffer of frame summaries.
// ----------------------------------------------------------------------------
module ftx_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  ftx_pkg::frame_sum_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output ftx_pkg::frame_sum_t rd_data,
    output logic                empty
);
    import ftx_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    frame_sum_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/ftx_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftx_back
// Classifies a frame summary and holds the result in the output register.
// ----------------------------------------------------------------------------
module ftx_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sum_avail,
    input  ftx_pkg::frame_sum_t    sum,
    output logic                   sum_take,
    output ftx_pkg::result_word_t  result,
    output logic                   empty,
    input  logic                   pop
);
    import ftx_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_word_t out_reg;
    result_word_t res;
    logic [15:0]  port_off;
    logic         is_tcp;
    logic         is_udp;
    logic         hdr_short;

    assign port_off = ETH_HDR_LEN + {10'd0, sum.ihl, 2'b00};
    assign is_tcp   = (sum.protocol == PROTO_TCP);
    assign is_udp   = (sum.protocol == PROTO_UDP);

    // The port offset never exceeds 74, so the sums below cannot wrap.
    assign hdr_short = (sum.frame_len < IPV4_MIN_END)
                    || (sum.frame_len < port_off)
                    || (is_tcp && sum.frame_len < port_off + TCP_MIN_LEN)
                    || (is_udp && sum.frame_len < port_off + UDP_MIN_LEN);

    always_comb
    begin
        res = '0;
        if (sum.frame_len < ETH_HDR_LEN)
        begin
            res.status = STATUS_SHORT;
        end
        else if (sum.eth_type != TYPE_IPV4)
        begin
            res.status   = STATUS_NOT_IPV4;
            res.eth_type = sum.eth_type;
        end
        else if (hdr_short)
        begin
            res.status = STATUS_SHORT;
        end
        else
        begin
            res.status   = STATUS_VALID;
            res.eth_type = sum.eth_type;
            res.ip_ver   = IPV4_VER;
            res.protocol = sum.protocol;
            res.ip_len   = sum.ip_len;
            res.src_addr = sum.src_addr;
            res.dst_addr = sum.dst_addr;
            if (is_tcp || is_udp)
            begin
                res.src_l4_port = sum.src_l4_port;
                res.dst_l4_port = sum.dst_l4_port;
            end
        end
    end

    assign sum_take = sum_avail && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (sum_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_take)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

endmodule

@@ rtl/core/ipv4_five_tuple_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_five_tuple_extractor
// Ethernet / IPv4 / TCP-UDP five-tuple extractor, one frame byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   Input side: write one frame byte per word with push while full is low;
//   last_byte marks the final byte of a frame. Any number of idle cycles may
//   fall between bytes. Output side: one result word per frame appears while
//   empty is low and is removed with pop.
//   Throughput is one byte per clock while full is low; a one-byte frame may
//   follow another back to back, giving one result per clock while pop is held high.
//   The summary of a frame is written into the summary queue when its last
//   byte is accepted; the classifier then registers its result in the output
//   register once that register is empty or being popped, and it stays until popped.
//   The parser writes a frame summary into a QUEUE_DEPTH-entry queue; full
//   rises only when that queue and the output register are all occupied,
//   which happens only when the receiver stalls with pop low.
//   Reset clears the byte counter, all captured fields, the queue and the valid
//   flag of the output register; the first byte after reset is the first byte of a frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_five_tuple_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  ftx_pkg::in_word_t     item,
    output logic                  empty,
    input  logic                  pop,
    output ftx_pkg::result_word_t result
);
    import ftx_pkg::*;

    logic       accept;
    logic       sum_valid;
    frame_sum_t sum_in;
    frame_sum_t sum_out;
    logic       q_empty;
    logic       sum_take;

    assign accept = push && !full;

    ftx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .sum_valid (sum_valid),
        .sum       (sum_in)
    );

    ftx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (sum_valid),
        .wr_data (sum_in),
        .full    (full),
        .rd_en   (sum_take),
        .rd_data (sum_out),
        .empty   (q_empty)
    );

    ftx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_avail (!q_empty),
        .sum       (sum_out),
        .sum_take  (sum_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    `ASSERT_IMPLY(a_short_zero, clk, rst_n,
        !empty && result.status == STATUS_SHORT,
        result.eth_type == 16'd0 && result.src_addr == 32'd0 && result.dst_addr == 32'd0,
        "short-frame result carries nonzero fields")

    `ASSERT_IMPLY(a_invalid_no_tuple, clk, rst_n,
        !empty && result.status != STATUS_VALID,
        result.ip_ver == 3'd0 && result.src_l4_port == 16'd0 && result.dst_l4_port == 16'd0,
        "non-valid result carries version or ports")

    `ASSERT_IMPLY(a_valid_ipv4, clk, rst_n,
        !empty && result.status == STATUS_VALID,
        result.ip_ver == IPV4_VER && result.eth_type == TYPE_IPV4,
        "valid result without IPv4 ethertype and version")

    `ASSERT_NEXT(a_mid_frame_no_result, clk, rst_n,
        empty && !(push && !full && item.last_byte) && q_empty,
        empty,
        "result appeared without a completed frame")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the IPv4 five-tuple extractor. Frames are pushed one byte
// per word: a directed set of edge cases first, then random frames of all
// kinds. A predictor written from the frame layout computes the five-tuple
// of each frame, and every result word is checked field by field.
// ----------------------------------------------------------------------------
module tb;

    import ftx_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TOTAL_BYTES  = 1050;

    // Predicts the result word of each frame from its bytes and holds the
    // predictions until the block delivers them.
    class tuple_checker;
        logic [15:0]  count;
        logic [15:0]  etype;
        logic [3:0]   ihl;
        logic [7:0]   proto;
        logic [15:0]  tlen;
        logic [31:0]  saddr;
        logic [31:0]  daddr;
        logic [15:0]  sport;
        logic [15:0]  dport;
        result_word_t pending_tuples[$];
        int           mismatch_count;
        string        field_name[9];

        function new();
            field_name = '{"status", "eth_type", "ip_ver", "protocol",
                           "ip_len", "src_addr", "dst_addr",
                           "src_l4_port", "dst_l4_port"};
            mismatch_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            count = '0;
            etype = '0;
            ihl   = '0;
            proto = '0;
            tlen  = '0;
            saddr = '0;
            daddr = '0;
            sport = '0;
            dport = '0;
        endfunction

        function void absorb_byte(in_word_t w);
            int           p;
            int           port_at;
            int           flen;
            logic [7:0]   b;
            result_word_t r;
            b = w.data_byte;
            p = count;
            if (p == POS_TYPE_HI) etype[15:8] = b;
            if (p == POS_TYPE_LO) etype[7:0] = b;
            if (p == POS_VER_IHL) ihl = b[3:0];
            if (p == POS_TLEN_HI) tlen[15:8] = b;
            if (p == POS_TLEN_LO) tlen[7:0] = b;
            if (p == POS_PROTO) proto = b;
            if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST) saddr = {saddr[23:0], b};
            if (p >= POS_DST_FIRST && p <= POS_DST_LAST) daddr = {daddr[23:0], b};
            // The port offset uses the IHL as it stands after this byte, so
            // with an IHL of zero byte 14 itself is the high source port byte.
            port_at = int'(ETH_HDR_LEN) + 4 * int'(ihl);
            if (p == port_at) sport[15:8] = b;
            else if (p == port_at + 1) sport[7:0] = b;
            else if (p == port_at + 2) dport[15:8] = b;
            else if (p == port_at + 3) dport[7:0] = b;
            if (count != COUNT_MAX) count = count + 16'd1;
            if (w.last_byte)
            begin
                flen = count;
                r = '0;
                if (flen < int'(ETH_HDR_LEN))
                begin
                    r.status = STATUS_SHORT;
                end
                else if (etype != TYPE_IPV4)
                begin
                    r.status = STATUS_NOT_IPV4;
                    r.eth_type = etype;
                end
                else if (flen < int'(IPV4_MIN_END) || flen < port_at ||
                         (proto == PROTO_TCP && flen < port_at + int'(TCP_MIN_LEN)) ||
                         (proto == PROTO_UDP && flen < port_at + int'(UDP_MIN_LEN)))
                begin
                    r.status = STATUS_SHORT;
                end
                else
                begin
                    r.status   = STATUS_VALID;
                    r.eth_type = etype;
                    r.ip_ver   = IPV4_VER;
                    r.protocol = proto;
                    r.ip_len   = tlen;
                    r.src_addr = saddr;
                    r.dst_addr = daddr;
                    if (proto == PROTO_TCP || proto == PROTO_UDP)
                    begin
                        r.src_l4_port = sport;
                        r.dst_l4_port = dport;
                    end
                end
                pending_tuples.push_back(r);
                clear_frame();
            end
        endfunction

        function logic [31:0] field_of(result_word_t r, int k);
            case (k)
                0: field_of = 32'(r.status);
                1: field_of = 32'(r.eth_type);
                2: field_of = 32'(r.ip_ver);
                3: field_of = 32'(r.protocol);
                4: field_of = 32'(r.ip_len);
                5: field_of = r.src_addr;
                6: field_of = r.dst_addr;
                7: field_of = 32'(r.src_l4_port);
                default: field_of = 32'(r.dst_l4_port);
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("tb: mismatch at %0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task compare_tuple(result_word_t got);
            result_word_t want;
            if (pending_tuples.size() == 0)
            begin
                report_mismatch("result word with no frame waiting");
            end
            else
            begin
                want = pending_tuples.pop_front();
                for (int k = 0; k < 9; k++)
                begin
                    if (field_of(got, k) !== field_of(want, k))
                        report_mismatch($sformatf("%s got %0h expected %0h",
                            field_name[k], field_of(got, k), field_of(want, k)));
                end
            end
        endtask

        function int waiting();
            return pending_tuples.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         push;
    logic         full;
    in_word_t     item;
    logic         empty;
    logic         pop;
    result_word_t result;

    tuple_checker sb;
    logic [7:0]   frame_buf[$];
    int           stall_cycles = 0;
    int           sent_bytes = 0;
    bit           calm = 1'b0;
    bit           hold_request = 1'b0;
    bit           hold_done = 1'b0;

    always #5 clk = ~clk;

    ipv4_five_tuple_extractor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    // Both handshakes are sampled here, before the drivers change anything.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
            if (push && !full)
                sb.absorb_byte(item);
            if (pop && !empty)
                sb.compare_tuple(result);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb: FAIL");
        $finish;
    end

    // Receiver: random pops, one long hold-off that lets the block fill up.
    initial
    begin
        pop <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                pop <= calm || ($urandom_range(0, 99) >= 10);
                @(posedge clk);
            end
        end
    end

    // fill: 0 random bytes, 1 all zeros, 2 all ones. Header fields that
    // decide the parse are written over the fill where the frame reaches them.
    task automatic build_frame(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input int len, input int fill);
        logic [7:0] b;
        frame_buf.delete();
        for (int i = 0; i < len; i++)
        begin
            b = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hFF : 8'($urandom_range(0, 255));
            if (i == POS_TYPE_HI) b = etype[15:8];
            if (i == POS_TYPE_LO) b = etype[7:0];
            if (i == POS_VER_IHL) b[3:0] = ihl;
            if (i == POS_PROTO) b = proto;
            frame_buf.push_back(b);
        end
    endtask

    task automatic send_word(input in_word_t w);
        if (!calm && $urandom_range(0, 99) < 7)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_frame();
        in_word_t w;
        for (int i = 0; i < frame_buf.size(); i++)
        begin
            w.data_byte = frame_buf[i];
            w.last_byte = (i == frame_buf.size() - 1);
            send_word(w);
        end
    endtask

    task automatic frame(input logic [15:0] etype, input logic [3:0] ihl,
                         input logic [7:0] proto, input int len, input int fill);
        build_frame(etype, ihl, proto, len, fill);
        send_frame();
        sent_bytes += frame_buf.size();
    endtask

    task automatic random_frame();
        int         kind;
        int         pick;
        int         need;
        int         len;
        logic [3:0] ihl;
        logic [7:0] proto;
        logic [15:0] etype;
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            etype = ($urandom_range(0, 1) == 0) ? TYPE_IPV4 : 16'($urandom_range(0, 65535));
            frame(etype, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  $urandom_range(1, 13), 0);
        end
        else if (kind < 27)
        begin
            frame(16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
                  8'($urandom_range(0, 255)), $urandom_range(14, 60), 0);
        end
        else
        begin
            ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
            pick = $urandom_range(0, 2);
            proto = (pick == 0) ? PROTO_TCP : (pick == 1) ? PROTO_UDP
                                            : 8'($urandom_range(0, 255));
            need = int'(ETH_HDR_LEN) + 4 * int'(ihl);
            if (proto == PROTO_TCP) need += int'(TCP_MIN_LEN);
            if (proto == PROTO_UDP) need += int'(UDP_MIN_LEN);
            if (need < int'(IPV4_MIN_END)) need = int'(IPV4_MIN_END);
            len = need + $urandom_range(0, 12) - $urandom_range(0, 3);
            frame(TYPE_IPV4, ihl, proto, len, 0);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        push  <= 1'b0;
        item  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The receiver holds off while the first frames fill the block.
        hold_request = 1'b1;

        // Directed frames: lengths on both sides of each threshold, the UDP one at IHL 15 only from above.
        frame(16'h0000, 4'd0, 8'd0, 1, 0);
        frame(TYPE_IPV4, 4'd5, PROTO_TCP, 13, 0);
        frame(16'hFFFF, 4'hF, 8'hFF, 14, 2);
        frame(16'h0000, 4'd0, 8'd0, 14, 1);
        frame(TYPE_IPV4, 4'd5, PROTO_TCP, 14, 0);
        frame(TYPE_IPV4, 4'd5, 8'd1, 33, 0);
        frame(TYPE_IPV4, 4'd5, 8'd1, 34, 0);
        calm = 1'b1;
        frame(TYPE_IPV4, 4'd5, PROTO_TCP, 53, 0);
        frame(TYPE_IPV4, 4'd5, PROTO_TCP, 54, 0);
        frame(TYPE_IPV4, 4'd5, PROTO_UDP, 41, 0);
        frame(TYPE_IPV4, 4'd5, PROTO_UDP, 42, 0);
        frame(TYPE_IPV4, 4'hF, 8'd1, 73, 0);
        frame(TYPE_IPV4, 4'hF, 8'd1, 74, 0);
        frame(TYPE_IPV4, 4'hF, PROTO_TCP, 93, 0);
        frame(TYPE_IPV4, 4'hF, PROTO_TCP, 94, 2);
        frame(TYPE_IPV4, 4'hF, PROTO_UDP, 82, 0);
        calm = 1'b0;
        // An IHL below five puts the ports inside the IPv4 header.
        frame(TYPE_IPV4, 4'd0, PROTO_UDP, 34, 0);
        frame(TYPE_IPV4, 4'd0, PROTO_TCP, 34, 0);
        frame(TYPE_IPV4, 4'd0, 8'd0, 34, 1);
        frame(TYPE_IPV4, 4'd3, PROTO_TCP, 45, 0);
        frame(TYPE_IPV4, 4'd3, PROTO_TCP, 46, 0);
        frame(TYPE_IPV4, 4'd2, PROTO_UDP, 34, 2);

        while (sent_bytes < TOTAL_BYTES)
            random_frame();
        push <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.waiting() != 0)
            sb.report_mismatch("frame result never arrived");
        if (sb.mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/ftx_pkg.sv
rtl/core/ftx_front.sv
rtl/core/ftx_queue.sv
rtl/core/ftx_back.sv
rtl/core/ipv4_five_tuple_extractor.sv
verif/tb.sv
